// ===== src/psq_pkg.sv =====
// Shared types, constants and helper functions for the stepper phase sequencer.
// Used by psq_step, stepper_phase_sequencer and psq_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

    // Default width of the internal step counter.
    localparam int STEP_COUNT_WIDTH_DEF = 16;

    // Fixed payload widths.
    localparam int ACTION_W = 3;
    localparam int COUNT_IN_W = 16;
    localparam int COUNT_OUT_W = 16;
    localparam int COIL_W = 4;
    localparam int PHASE_W = 3;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_START      = 3'd1,
        ACT_PAUSE_HOLD = 3'd2,
        ACT_PAUSE_FREE = 3'd3,
        ACT_RESUME     = 3'd4,
        ACT_HALT       = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        RUN_READY   = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_HOLDING = 2'd2,
        RUN_FREE    = 2'd3
    } t_run_state;

    typedef enum logic [1:0] {
        MODE_WAVE    = 2'd0,
        MODE_FULL    = 2'd1,
        MODE_HALF    = 2'd2,
        MODE_INVALID = 2'd3
    } t_step_mode;

    // Sequencer state apart from the step counter and the coil bits.
    typedef struct packed {
        t_run_state         run;
        logic [PHASE_W-1:0] phase;
        t_step_mode         mode;
        logic               dir;
        logic               endless;
    } t_seq_state;

    // Per-request status flags.
    typedef struct packed {
        logic done;
        logic err;
    } t_step_flags;

    localparam logic [COIL_W-1:0] WAVE_TAB [0:3] = '{4'b1000, 4'b0100, 4'b0010, 4'b0001};
    localparam logic [COIL_W-1:0] FULL_TAB [0:3] = '{4'b1001, 4'b1100, 4'b0110, 4'b0011};
    localparam logic [COIL_W-1:0] HALF_TAB [0:7] = '{4'b1000, 4'b1100, 4'b0100, 4'b0110,
                                                      4'b0010, 4'b0011, 4'b0001, 4'b1001};

    // Coil pattern at a table position for the given mode.
    function automatic logic [COIL_W-1:0] coil_entry(t_step_mode mode, logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (mode)
            MODE_HALF: pat = HALF_TAB[idx];
            MODE_FULL: pat = FULL_TAB[idx[1:0]];
            default:   pat = WAVE_TAB[idx[1:0]];
        endcase
        return pat;
    endfunction

    // Index mask: eight entries for half step, four otherwise.
    function automatic logic [PHASE_W-1:0] phase_mask(t_step_mode mode);
        logic [PHASE_W-1:0] m;
        m = (mode == MODE_HALF) ? 3'd7 : 3'd3;
        return m;
    endfunction

    // Next table position, wrapping in either direction.
    function automatic logic [PHASE_W-1:0] next_phase(t_step_mode mode, logic dir,
                                                      logic [PHASE_W-1:0] idx);
        logic [PHASE_W-1:0] moved;
        moved = dir ? (idx - 3'd1) : (idx + 3'd1);
        return moved & phase_mask(mode);
    endfunction

endpackage

`default_nettype wire

// ===== src/psq_step.sv =====
// Combinational update logic of the stepper phase sequencer: next state, coils and flags.
// Depends on psq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psq_step #(
    parameter int STEP_COUNT_WIDTH = psq_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic [psq_pkg::ACTION_W-1:0]   i_action,
    input  logic [psq_pkg::COUNT_IN_W-1:0] i_step_count,
    input  logic                           i_direction,
    input  logic [1:0]                     i_step_mode,
    input  logic                           i_run_forever,
    input  psq_pkg::t_seq_state            i_cur,
    input  logic [STEP_COUNT_WIDTH-1:0]    i_steps,
    input  logic [psq_pkg::COIL_W-1:0]     i_drive,
    output psq_pkg::t_seq_state            o_nxt,
    output logic [STEP_COUNT_WIDTH-1:0]    o_steps,
    output logic [psq_pkg::COIL_W-1:0]     o_drive,
    output psq_pkg::t_step_flags           o_flags
);

    psq_pkg::t_action    act;
    psq_pkg::t_step_mode req_mode;
    logic                running;
    logic                tick_end;
    logic                tick_step;

    assign act      = psq_pkg::t_action'(i_action);
    assign req_mode = psq_pkg::t_step_mode'(i_step_mode);
    assign running  = (i_cur.run == psq_pkg::RUN_RUNNING);
    // A counted move ends on the tick that finds the counter already at zero.
    assign tick_end  = running && !i_cur.endless && (i_steps == '0);
    assign tick_step = running && !tick_end;

    // Next state.
    always_comb begin
        o_nxt   = i_cur;
        o_steps = i_steps;
        case (act)
            psq_pkg::ACT_TICK: begin
                if (tick_end) begin
                    o_nxt.run = psq_pkg::RUN_READY;
                end else if (tick_step) begin
                    o_nxt.phase = psq_pkg::next_phase(i_cur.mode, i_cur.dir, i_cur.phase);
                    if (!i_cur.endless) begin
                        o_steps = i_steps - STEP_COUNT_WIDTH'(1);
                    end
                end
            end
            psq_pkg::ACT_START: begin
                if (req_mode != psq_pkg::MODE_INVALID) begin
                    o_nxt.mode    = req_mode;
                    o_nxt.dir     = i_direction;
                    o_nxt.endless = i_run_forever;
                    o_steps       = STEP_COUNT_WIDTH'(i_step_count);
                    o_nxt.phase   = i_direction ? psq_pkg::phase_mask(req_mode) : '0;
                    o_nxt.run     = psq_pkg::RUN_RUNNING;
                end
            end
            psq_pkg::ACT_PAUSE_HOLD: begin
                if (i_cur.run != psq_pkg::RUN_READY) begin
                    o_nxt.run = psq_pkg::RUN_HOLDING;
                end
            end
            psq_pkg::ACT_PAUSE_FREE: begin
                if (i_cur.run != psq_pkg::RUN_READY) begin
                    o_nxt.run = psq_pkg::RUN_FREE;
                end
            end
            psq_pkg::ACT_RESUME: begin
                if (i_cur.run == psq_pkg::RUN_HOLDING || i_cur.run == psq_pkg::RUN_FREE) begin
                    o_nxt.run = psq_pkg::RUN_RUNNING;
                end
            end
            psq_pkg::ACT_HALT: begin
                o_nxt.run = psq_pkg::RUN_READY;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

    // Coil drive and status flags.
    always_comb begin
        o_drive = i_drive;
        o_flags = '0;
        case (act)
            psq_pkg::ACT_TICK: begin
                if (i_cur.run == psq_pkg::RUN_FREE) begin
                    o_drive = '0;
                end else if (tick_step) begin
                    o_drive = psq_pkg::coil_entry(i_cur.mode, i_cur.phase);
                end
                o_flags.done = tick_end;
            end
            psq_pkg::ACT_START: begin
                o_flags.err = (req_mode == psq_pkg::MODE_INVALID);
            end
            psq_pkg::ACT_PAUSE_FREE: begin
                if (i_cur.run != psq_pkg::RUN_READY) begin
                    o_drive = '0;
                end
            end
            default: begin
                o_drive = i_drive;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/stepper_phase_sequencer.sv =====
// Top level of the four-coil stepper phase sequencer: request register, state, result register.
// Depends on psq_pkg and psq_step.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------------
//  request  | i_in_valid / o_in_stall    | i_action, i_step_count, i_direction,
//           |                            | i_step_mode, i_run_forever
//  result   | o_out_valid / i_out_stall  | o_coil_pattern, o_motor_state,
//           |                            | o_steps_remaining, o_move_done, o_command_error
//
// One request is taken every cycle while o_in_stall is low; each yields exactly one result.
// An accepted request waits in the input register; at the next edge with the result register
// free, the state update and the result are captured together. The state loop through
// psq_step is combinational, which sets the one-per-cycle rate while no stall holds the flow.
// Reset (synchronous, active low) empties both registers and returns the motor to ready.
// A stalled result is held, and o_in_stall rises only when both registers are full.

module stepper_phase_sequencer #(
    parameter int STEP_COUNT_WIDTH = psq_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [psq_pkg::ACTION_W-1:0]    i_action,
    input  logic [psq_pkg::COUNT_IN_W-1:0]  i_step_count,
    input  logic                            i_direction,
    input  logic [1:0]                      i_step_mode,
    input  logic                            i_run_forever,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [psq_pkg::COIL_W-1:0]      o_coil_pattern,
    output logic [1:0]                      o_motor_state,
    output logic [psq_pkg::COUNT_OUT_W-1:0] o_steps_remaining,
    output logic                            o_move_done,
    output logic                            o_command_error
);

    // Input register.
    logic                           r_req_valid;
    logic [psq_pkg::ACTION_W-1:0]   r_action;
    logic [psq_pkg::COUNT_IN_W-1:0] r_step_count;
    logic                           r_direction;
    logic [1:0]                     r_step_mode;
    logic                           r_run_forever;

    // Sequencer state.
    psq_pkg::t_seq_state         r_state;
    logic [STEP_COUNT_WIDTH-1:0] r_steps;
    logic [psq_pkg::COIL_W-1:0]  r_drive;

    psq_pkg::t_seq_state         n_state;
    logic [STEP_COUNT_WIDTH-1:0] n_steps;
    logic [psq_pkg::COIL_W-1:0]  n_drive;
    psq_pkg::t_step_flags        n_flags;

    // Result register.
    logic                            r_out_valid;
    logic [psq_pkg::COIL_W-1:0]      r_coil;
    logic [1:0]                      r_motor;
    logic [psq_pkg::COUNT_OUT_W-1:0] r_remaining;
    psq_pkg::t_step_flags            r_flags;

    logic out_free;
    logic req_move;
    logic in_take;

    // The result register can load when it is empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    // The held request is executed exactly when it moves into the result register.
    assign req_move   = r_req_valid && out_free;
    assign o_in_stall = r_req_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    psq_step #(
        .STEP_COUNT_WIDTH(STEP_COUNT_WIDTH)
    ) u_step (
        .i_action     (r_action),
        .i_step_count (r_step_count),
        .i_direction  (r_direction),
        .i_step_mode  (r_step_mode),
        .i_run_forever(r_run_forever),
        .i_cur        (r_state),
        .i_steps      (r_steps),
        .i_drive      (r_drive),
        .o_nxt        (n_state),
        .o_steps      (n_steps),
        .o_drive      (n_drive),
        .o_flags      (n_flags)
    );

    // Control: valid flags and the sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.run     <= psq_pkg::RUN_READY;
            r_state.phase   <= '0;
            r_state.mode    <= psq_pkg::MODE_WAVE;
            r_state.dir     <= 1'b0;
            r_state.endless <= 1'b0;
            r_steps       <= '0;
            r_drive       <= '0;
        end else begin
            if (in_take) begin
                r_req_valid <= 1'b1;
            end else if (req_move) begin
                r_req_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_req_valid;
            end
            if (req_move) begin
                r_state <= n_state;
                r_steps <= n_steps;
                r_drive <= n_drive;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action      <= i_action;
            r_step_count  <= i_step_count;
            r_direction   <= i_direction;
            r_step_mode   <= i_step_mode;
            r_run_forever <= i_run_forever;
        end
        if (req_move) begin
            r_coil      <= n_drive;
            r_motor     <= n_state.run;
            r_remaining <= psq_pkg::COUNT_OUT_W'(n_steps);
            r_flags     <= n_flags;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_coil_pattern    = r_coil;
    assign o_motor_state     = r_motor;
    assign o_steps_remaining = r_remaining;
    assign o_move_done       = r_flags.done;
    assign o_command_error   = r_flags.err;

endmodule

`default_nettype wire

// ===== src/psq_checker.sv =====
// Port-level checks on the stepper phase sequencer results, bound to the top level.
// Depends on psq_pkg and stepper_phase_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module psq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_stall,
    input logic [psq_pkg::COIL_W-1:0]      i_coil_pattern,
    input logic [1:0]                      i_motor_state,
    input logic [psq_pkg::COUNT_OUT_W-1:0] i_steps_remaining,
    input logic                            i_move_done,
    input logic                            i_command_error
);

    // A finished move always leaves the motor ready.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_move_done) |-> (i_motor_state == psq_pkg::RUN_READY))
        else $error("move_done with motor not ready");

    // A move only finishes once its counter has run out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_move_done) |-> (i_steps_remaining == '0))
        else $error("move_done with steps remaining");

    // A rejected start is never also the end of a move.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_move_done && i_command_error))
        else $error("move_done and command_error together");

    // Free-wheeling always means the coils are off.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_motor_state == psq_pkg::RUN_FREE) |-> (i_coil_pattern == '0))
        else $error("coils driven while free");

    // A stalled result is held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_coil_pattern)
            && $stable(i_motor_state) && $stable(i_steps_remaining)))
        else $error("stalled result changed");

endmodule

bind stepper_phase_sequencer psq_checker u_psq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_coil_pattern   (o_coil_pattern),
    .i_motor_state    (o_motor_state),
    .i_steps_remaining(o_steps_remaining),
    .i_move_done      (o_move_done),
    .i_command_error  (o_command_error)
);

`default_nettype wire
